FILE: sv/dsd_frame_fifo_with_prebuffer_assert.svh
// Assertion macros shared by the frame FIFO RTL.
// Both macros expect a signal named clk, and DSDFF_ASSERT also one named rst, in the module that uses it.
`ifndef DSD_FRAME_FIFO_WITH_PREBUFFER_ASSERT_SVH
`define DSD_FRAME_FIFO_WITH_PREBUFFER_ASSERT_SVH

// Checked outside reset only.
`define DSDFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define DSDFF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/dsdff_pkg.sv
`default_nettype none

package dsdff_pkg;

  // Store geometry. The ring holds at most STORE_DEPTH - 1 frames.
  localparam int STORE_DEPTH  = 4096;
  localparam int PTR_W        = $clog2(STORE_DEPTH);
  localparam int MAX_CHANNELS = 8;
  localparam int FRAME_W      = 8 * MAX_CHANNELS;

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int CH_W    = 4;
  localparam int READY_W = 12;
  localparam int TMO_W   = 16;
  localparam int CNT_W   = 48;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 16;

  // Packed widths of the stream words.
  localparam int IN_USER_W = CMD_W + 1;
  localparam int IN_DATA_W = ((FRAME_W + 7) / 8) * 8;
  localparam int OUT_BITS  = FRAME_W + 2 + READY_W + 3 * CNT_W + 2;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [CH_W-1:0]    ch_t;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PULL  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ENDED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd4;

  // Register indexes.
  localparam logic [CFG_A_W-1:0] REG_CH_COUNT  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_OCH_COUNT = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_PB_FRAMES = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_PB_TMO    = 2'd3;

  localparam logic [7:0]       SILENCE_BYTE  = 8'h69;
  localparam frame_t           SILENCE_FRAME = {MAX_CHANNELS{SILENCE_BYTE}};
  localparam cnt_t             CNT_MAX       = {CNT_W{1'b1}};
  localparam cnt_t             BITS_PER_FRAME = CNT_W'(8);
  localparam ptr_t             FILL_MAX      = PTR_W'(STORE_DEPTH - 1);
  localparam logic [TMO_W-1:0] TMO_MAX       = {TMO_W{1'b1}};

  // Saturating add of a counter and a small step.
  function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
    return (a >= CNT_MAX - b) ? CNT_MAX : a + b;
  endfunction

  // Ring pointer advance, also for depths that are not a power of two.
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == FILL_MAX) ? '0 : p + PTR_W'(1);
  endfunction

  // Channel count limited to 1..MAX_CHANNELS.
  function automatic ch_t clamp_ch(input ch_t n);
    ch_t r;
    if (n == '0) begin
      r = CH_W'(1);
    end else if (n > CH_W'(MAX_CHANNELS)) begin
      r = CH_W'(MAX_CHANNELS);
    end else begin
      r = n;
    end
    return r;
  endfunction

  // Output channel c takes stored channel min(c, ich-1); unused channels are silent.
  function automatic frame_t map_frame(input frame_t stored, input ch_t ch_cnt,
                                       input ch_t och_cnt);
    ch_t    ich;
    ch_t    och;
    ch_t    last;
    ch_t    src;
    frame_t r;
    ich  = clamp_ch(ch_cnt);
    och  = clamp_ch(och_cnt);
    last = ich - CH_W'(1);
    r    = SILENCE_FRAME;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (CH_W'(c) < och) begin
        src = (CH_W'(c) < last) ? CH_W'(c) : last;
        r[8*c +: 8] = stored[8*src +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dsdff_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module dsdff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/dsd_frame_fifo_with_prebuffer.sv
`default_nettype none

// FIFO of multichannel DSD byte frames with startup prebuffering. Frames live in a
// 4096 x 64 block RAM with one write and one registered read port, so the store holds
// up to 4095 frames; entries are never cleared, since only written entries are read.
// Push, begin session, input ended, tick, and pulls that give silence load the result
// register directly; a pull that takes a frame from the store first goes through a
// read state, since the registered RAM read sits between the pointer and the remapped
// frame. Every word gives one result word, kept in an output register, and the next
// word is taken while no read is pending and that register is empty or being taken
// in the same cycle. Configuration writes through cfg_we, cfg_addr and cfg_data take
// effect at the next edge and belong in gaps where no word is in flight.
module dsd_frame_fifo_with_prebuffer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration.
  input  wire logic                               cfg_we,
  input  wire logic [dsdff_pkg::CFG_A_W-1:0]      cfg_addr,
  input  wire logic [dsdff_pkg::CFG_D_W-1:0]      cfg_data,
  // Input stream.
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // tdata: frame_data[63:0]
  input  wire logic [dsdff_pkg::IN_DATA_W-1:0]    s_tdata,
  // tuser: command[2:0], call_start[3]
  input  wire logic [dsdff_pkg::IN_USER_W-1:0]    s_tuser,
  // Result stream.
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // tdata: out_frame[63:0], from_store[64], push_accepted[65], ready_frames[77:66],
  //        played_count[125:78], underrun_call_count[173:126],
  //        underrun_bit_count[221:174], drained[222], holding[223]
  output logic [dsdff_pkg::OUT_DATA_W-1:0]        m_tdata
);

  `include "dsd_frame_fifo_with_prebuffer_assert.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Configuration registers.
  dsdff_pkg::ch_t                    ch_cnt;
  dsdff_pkg::ch_t                    och_cnt;
  logic [dsdff_pkg::READY_W-1:0]     pb_frames;
  logic [dsdff_pkg::TMO_W-1:0]       pb_tmo;

  // Control state.
  logic                              state, state_next;
  dsdff_pkg::ptr_t                   rd_ptr, rd_ptr_next;
  dsdff_pkg::ptr_t                   wr_ptr, wr_ptr_next;
  dsdff_pkg::ptr_t                   fill, fill_next;
  logic                              pb_active, pb_active_next;
  logic                              input_done, input_done_next;
  logic                              audio_seen, audio_seen_next;
  logic                              call_held, call_held_next;
  logic                              call_dry, call_dry_next;
  logic                              call_cu, call_cu_next;
  logic [dsdff_pkg::TMO_W-1:0]       elapsed, elapsed_next;
  dsdff_pkg::cnt_t                   played, played_next;
  dsdff_pkg::cnt_t                   ucalls, ucalls_next;
  dsdff_pkg::cnt_t                   ubits, ubits_next;

  // Output register.
  logic                              out_valid;
  dsdff_pkg::frame_t                 out_frame;
  logic                              out_from_store;
  logic                              out_push_acc;
  logic [dsdff_pkg::READY_W-1:0]     out_ready;
  dsdff_pkg::cnt_t                   out_played;
  dsdff_pkg::cnt_t                   out_ucalls;
  dsdff_pkg::cnt_t                   out_ubits;
  logic                              out_drained;
  logic                              out_holding;

  // Result of the current word.
  logic                              load;
  dsdff_pkg::frame_t                 res_frame;
  logic                              res_from_store;
  logic                              res_push_acc;

  // RAM interface.
  logic                              ram_we;
  logic                              ram_re;
  dsdff_pkg::frame_t                 ram_rdata;

  logic                              in_fire;
  logic [dsdff_pkg::CMD_W-1:0]       cmd;
  logic                              call_start;
  dsdff_pkg::frame_t                 frame_data;
  logic                              enough;
  logic                              timed_out;

  assign cmd        = s_tuser[dsdff_pkg::CMD_W-1:0];
  assign call_start = s_tuser[dsdff_pkg::CMD_W];
  assign frame_data = s_tdata[dsdff_pkg::FRAME_W-1:0];

  assign s_tready = (state == ST_IDLE) && (!out_valid || m_tready);
  assign in_fire  = s_tvalid && s_tready;

  assign enough    = dsdff_pkg::READY_W'(fill) >= pb_frames;
  assign timed_out = (pb_tmo == '0) || (elapsed >= pb_tmo);

  dsdff_ram #(
    .WIDTH(dsdff_pkg::FRAME_W),
    .DEPTH(dsdff_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(frame_data),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_cnt    <= dsdff_pkg::CH_W'(2);
      och_cnt   <= dsdff_pkg::CH_W'(2);
      pb_frames <= '0;
      pb_tmo    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dsdff_pkg::REG_CH_COUNT:  ch_cnt    <= cfg_data[dsdff_pkg::CH_W-1:0];
        dsdff_pkg::REG_OCH_COUNT: och_cnt   <= cfg_data[dsdff_pkg::CH_W-1:0];
        dsdff_pkg::REG_PB_FRAMES: pb_frames <= cfg_data[dsdff_pkg::READY_W-1:0];
        dsdff_pkg::REG_PB_TMO:    pb_tmo    <= cfg_data[dsdff_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode and state update.
  always_comb begin
    state_next      = state;
    rd_ptr_next     = rd_ptr;
    wr_ptr_next     = wr_ptr;
    fill_next       = fill;
    pb_active_next  = pb_active;
    input_done_next = input_done;
    audio_seen_next = audio_seen;
    call_held_next  = call_held;
    call_dry_next   = call_dry;
    call_cu_next    = call_cu;
    elapsed_next    = elapsed;
    played_next     = played;
    ucalls_next     = ucalls;
    ubits_next      = ubits;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    load            = 1'b0;
    res_frame       = dsdff_pkg::SILENCE_FRAME;
    res_from_store  = 1'b0;
    res_push_acc    = 1'b0;

    if (state == ST_READ) begin
      // Read state of a pull: the stored frame is on the RAM output.
      res_frame      = dsdff_pkg::map_frame(ram_rdata, ch_cnt, och_cnt);
      res_from_store = 1'b1;
      rd_ptr_next    = dsdff_pkg::ptr_inc(rd_ptr);
      fill_next      = fill - dsdff_pkg::PTR_W'(1);
      played_next    = dsdff_pkg::sat_add(played, dsdff_pkg::BITS_PER_FRAME);
      load           = 1'b1;
      state_next     = ST_IDLE;
    end else if (in_fire) begin
      load = 1'b1;
      unique case (cmd)
        dsdff_pkg::CMD_PUSH: begin
          audio_seen_next = 1'b1;
          if (fill < dsdff_pkg::FILL_MAX) begin
            ram_we       = 1'b1;
            wr_ptr_next  = dsdff_pkg::ptr_inc(wr_ptr);
            fill_next    = fill + dsdff_pkg::PTR_W'(1);
            res_push_acc = 1'b1;
          end
        end
        dsdff_pkg::CMD_PULL: begin
          if (och_cnt != '0) begin
            // First pull of a call decides the hold for the whole call.
            if (call_start) begin
              call_dry_next = 1'b0;
              call_cu_next  = 1'b0;
              if (!pb_active) begin
                call_held_next = 1'b0;
              end else if (enough || timed_out || input_done) begin
                pb_active_next = 1'b0;
                call_held_next = 1'b0;
              end else begin
                call_held_next = 1'b1;
              end
            end
            if (call_held_next) begin
              // Held: silence, nothing counted.
            end else if (call_dry_next) begin
              if (call_cu_next) begin
                ubits_next = dsdff_pkg::sat_add(ubits, dsdff_pkg::BITS_PER_FRAME);
              end
            end else if (fill != '0) begin
              // Frame available: read it and finish next cycle.
              ram_re     = 1'b1;
              load       = 1'b0;
              state_next = ST_READ;
            end else begin
              // The store ran dry inside this call.
              call_dry_next = 1'b1;
              call_cu_next  = !input_done && audio_seen;
              if (!input_done && audio_seen) begin
                ucalls_next = dsdff_pkg::sat_add(ucalls, dsdff_pkg::CNT_W'(1));
                ubits_next  = dsdff_pkg::sat_add(ubits, dsdff_pkg::BITS_PER_FRAME);
              end
            end
          end
        end
        dsdff_pkg::CMD_BEGIN: begin
          rd_ptr_next     = '0;
          wr_ptr_next     = '0;
          fill_next       = '0;
          elapsed_next    = '0;
          played_next     = '0;
          ucalls_next     = '0;
          ubits_next      = '0;
          input_done_next = 1'b0;
          audio_seen_next = 1'b0;
          pb_active_next  = (pb_frames != '0);
          call_held_next  = 1'b0;
          call_dry_next   = 1'b0;
          call_cu_next    = 1'b0;
        end
        dsdff_pkg::CMD_ENDED: begin
          input_done_next = 1'b1;
        end
        dsdff_pkg::CMD_TICK: begin
          if (elapsed != dsdff_pkg::TMO_MAX) begin
            elapsed_next = elapsed + dsdff_pkg::TMO_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      fill       <= '0;
      pb_active  <= 1'b0;
      input_done <= 1'b0;
      audio_seen <= 1'b0;
      call_held  <= 1'b0;
      call_dry   <= 1'b0;
      call_cu    <= 1'b0;
      elapsed    <= '0;
      played     <= '0;
      ucalls     <= '0;
      ubits      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      rd_ptr     <= rd_ptr_next;
      wr_ptr     <= wr_ptr_next;
      fill       <= fill_next;
      pb_active  <= pb_active_next;
      input_done <= input_done_next;
      audio_seen <= audio_seen_next;
      call_held  <= call_held_next;
      call_dry   <= call_dry_next;
      call_cu    <= call_cu_next;
      elapsed    <= elapsed_next;
      played     <= played_next;
      ucalls     <= ucalls_next;
      ubits      <= ubits_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word, a snapshot of the state after the word.
  always_ff @(posedge clk) begin
    if (load) begin
      out_frame      <= res_frame;
      out_from_store <= res_from_store;
      out_push_acc   <= res_push_acc;
      out_ready      <= dsdff_pkg::READY_W'(fill_next);
      out_played     <= played_next;
      out_ucalls     <= ucalls_next;
      out_ubits      <= ubits_next;
      out_drained    <= input_done_next && (fill_next == '0);
      out_holding    <= pb_active_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = dsdff_pkg::OUT_DATA_W'({out_holding, out_drained, out_ubits, out_ucalls,
                                            out_played, out_ready, out_push_acc,
                                            out_from_store, out_frame});

  // Checks on the store bookkeeping and the read sequence.
  `DSDFF_ASSERT(a_fill_max, fill <= dsdff_pkg::FILL_MAX, "fill count beyond capacity")
  `DSDFF_ASSERT(a_ptr_empty, (wr_ptr == rd_ptr) |-> (fill == '0), "pointers meet with frames held")
  `DSDFF_ASSERT(a_read_done, (state == ST_READ) |=> (state == ST_IDLE) && m_tvalid, "read hung")
  `DSDFF_ASSERT(a_drained, (out_valid && out_drained) |-> (out_ready == '0), "drained flag wrong")
  `DSDFF_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid && (state == ST_IDLE), "reset left state")

endmodule

`default_nettype wire

FILE: tb/sv/dsd_frame_fifo_with_prebuffer_tb.sv
`default_nettype none

module dsd_frame_fifo_with_prebuffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Result word as it sits on m_tdata, lowest field last.
  typedef struct packed {
    logic                            holding;
    logic                            drained;
    dsdff_pkg::cnt_t                 ubits;
    dsdff_pkg::cnt_t                 ucalls;
    dsdff_pkg::cnt_t                 played;
    logic [dsdff_pkg::READY_W-1:0]   ready;
    logic                            accepted;
    logic                            from_store;
    dsdff_pkg::frame_t               frame;
  } result_t;

  // Tracks the frame store and the session counters, and holds the result
  // words that are still owed by the block.
  class frame_fifo_scoreboard;
    dsdff_pkg::frame_t store [dsdff_pkg::STORE_DEPTH];
    int unsigned     rd_ptr;
    int unsigned     wr_ptr;
    int unsigned     fill;
    int unsigned     elapsed;
    bit              pb_active;
    bit              in_done;
    bit              audio;
    bit              held;
    bit              dry;
    bit              dry_counts;
    dsdff_pkg::cnt_t played;
    dsdff_pkg::cnt_t ucalls;
    dsdff_pkg::cnt_t ubits;
    logic [dsdff_pkg::CH_W-1:0]    ch_reg;
    logic [dsdff_pkg::CH_W-1:0]    och_reg;
    logic [dsdff_pkg::READY_W-1:0] pb_frames;
    logic [dsdff_pkg::TMO_W-1:0]   pb_tmo;
    result_t         due [$];
    int              errors;

    function new();
      rd_ptr = 0;
      wr_ptr = 0;
      fill = 0;
      elapsed = 0;
      pb_active = 0;
      in_done = 0;
      audio = 0;
      held = 0;
      dry = 0;
      dry_counts = 0;
      played = '0;
      ucalls = '0;
      ubits = '0;
      ch_reg = dsdff_pkg::CH_W'(2);
      och_reg = dsdff_pkg::CH_W'(2);
      pb_frames = '0;
      pb_tmo = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [dsdff_pkg::CFG_A_W-1:0] idx,
                            logic [dsdff_pkg::CFG_D_W-1:0] val);
      case (idx)
        dsdff_pkg::REG_CH_COUNT:  ch_reg = val[dsdff_pkg::CH_W-1:0];
        dsdff_pkg::REG_OCH_COUNT: och_reg = val[dsdff_pkg::CH_W-1:0];
        dsdff_pkg::REG_PB_FRAMES: pb_frames = val[dsdff_pkg::READY_W-1:0];
        dsdff_pkg::REG_PB_TMO:    pb_tmo = val[dsdff_pkg::TMO_W-1:0];
        default: ;
      endcase
    endfunction

    function dsdff_pkg::cnt_t add_bits(dsdff_pkg::cnt_t a, dsdff_pkg::cnt_t step);
      return (a >= dsdff_pkg::CNT_MAX - step) ? dsdff_pkg::CNT_MAX : a + step;
    endfunction

    function int limit_ch(logic [dsdff_pkg::CH_W-1:0] n);
      if (n == '0) return 1;
      if (n > dsdff_pkg::MAX_CHANNELS) return dsdff_pkg::MAX_CHANNELS;
      return int'(n);
    endfunction

    // Output channel c repeats the last stored channel once c runs past it.
    function dsdff_pkg::frame_t remap(dsdff_pkg::frame_t f);
      int                ich;
      int                och;
      int                src;
      dsdff_pkg::frame_t r;
      ich = limit_ch(ch_reg);
      och = limit_ch(och_reg);
      for (int c = 0; c < dsdff_pkg::MAX_CHANNELS; c++) begin
        if (c < och) begin
          src = (c < ich - 1) ? c : ich - 1;
          r[8*c +: 8] = f[8*src +: 8];
        end else begin
          r[8*c +: 8] = dsdff_pkg::SILENCE_BYTE;
        end
      end
      return r;
    endfunction

    // Decided at the first pull of a call: true keeps the whole call silent.
    function bit hold_call();
      if (!pb_active) return 0;
      if (fill >= pb_frames || pb_tmo == '0 || elapsed >= pb_tmo || in_done) begin
        pb_active = 0;
        return 0;
      end
      return 1;
    endfunction

    // Applies one accepted input word and queues the result it owes.
    function void note_word(logic [dsdff_pkg::CMD_W-1:0] cmd, dsdff_pkg::frame_t data,
                            bit start);
      result_t r;
      r = '0;
      r.frame = dsdff_pkg::SILENCE_FRAME;
      case (cmd)
        dsdff_pkg::CMD_PUSH: begin
          audio = 1;
          if (fill < dsdff_pkg::STORE_DEPTH - 1) begin
            store[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % dsdff_pkg::STORE_DEPTH;
            fill++;
            r.accepted = 1'b1;
          end
        end
        dsdff_pkg::CMD_PULL: begin
          // A zero output channel count turns the pull into a no-op.
          if (och_reg != '0) begin
            if (start) begin
              dry = 0;
              dry_counts = 0;
              held = hold_call();
            end
            if (!held) begin
              if (dry) begin
                if (dry_counts) ubits = add_bits(ubits, dsdff_pkg::BITS_PER_FRAME);
              end else if (fill > 0) begin
                r.frame = remap(store[rd_ptr]);
                rd_ptr = (rd_ptr + 1) % dsdff_pkg::STORE_DEPTH;
                fill--;
                r.from_store = 1'b1;
                played = add_bits(played, dsdff_pkg::BITS_PER_FRAME);
              end else begin
                // Running dry counts only while audio is still expected.
                dry = 1;
                dry_counts = !in_done && audio;
                if (dry_counts) begin
                  ucalls = add_bits(ucalls, dsdff_pkg::CNT_W'(1));
                  ubits = add_bits(ubits, dsdff_pkg::BITS_PER_FRAME);
                end
              end
            end
          end
        end
        dsdff_pkg::CMD_BEGIN: begin
          rd_ptr = 0;
          wr_ptr = 0;
          fill = 0;
          elapsed = 0;
          played = '0;
          ucalls = '0;
          ubits = '0;
          in_done = 0;
          audio = 0;
          pb_active = (pb_frames != '0);
          held = 0;
          dry = 0;
          dry_counts = 0;
        end
        dsdff_pkg::CMD_ENDED: in_done = 1;
        dsdff_pkg::CMD_TICK: if (elapsed < dsdff_pkg::TMO_MAX) elapsed++;
        default: ;
      endcase
      r.ready = dsdff_pkg::READY_W'(fill);
      r.played = played;
      r.ucalls = ucalls;
      r.ubits = ubits;
      r.drained = in_done && (fill == 0);
      r.holding = pb_active;
      due.push_back(r);
    endfunction

    task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      errors++;
    endtask

    task check_word(result_t got);
      result_t want;
      if (due.size() == 0) begin
        report_mismatch("unexpected word", got.frame, '0);
        return;
      end
      want = due.pop_front();
      if (got.frame !== want.frame) report_mismatch("out_frame", got.frame, want.frame);
      if (got.from_store !== want.from_store)
        report_mismatch("from_store", got.from_store, want.from_store);
      if (got.accepted !== want.accepted)
        report_mismatch("push_accepted", got.accepted, want.accepted);
      if (got.ready !== want.ready) report_mismatch("ready_frames", got.ready, want.ready);
      if (got.played !== want.played)
        report_mismatch("played_count", got.played, want.played);
      if (got.ucalls !== want.ucalls)
        report_mismatch("underrun_call_count", got.ucalls, want.ucalls);
      if (got.ubits !== want.ubits)
        report_mismatch("underrun_bit_count", got.ubits, want.ubits);
      if (got.drained !== want.drained) report_mismatch("drained", got.drained, want.drained);
      if (got.holding !== want.holding) report_mismatch("holding", got.holding, want.holding);
    endtask
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_we = 1'b0;
  logic [dsdff_pkg::CFG_A_W-1:0]      cfg_addr = '0;
  logic [dsdff_pkg::CFG_D_W-1:0]      cfg_data = '0;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [dsdff_pkg::IN_DATA_W-1:0]    s_tdata = '0;
  logic [dsdff_pkg::IN_USER_W-1:0]    s_tuser = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [dsdff_pkg::OUT_DATA_W-1:0]   m_tdata;

  bit quiet = 0;
  bit long_hold = 0;
  frame_fifo_scoreboard sb;

  dsd_frame_fifo_with_prebuffer uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Every result word taken is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(result_t'(m_tdata));
  end

  // Result side: random stalls, and one long hold-off on request.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        n = quiet ? 1 : $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic dsdff_pkg::frame_t rand_frame();
    return {$urandom, $urandom};
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offers one word and returns at the edge where it is taken; valid stays high.
  task automatic send_word(logic [dsdff_pkg::CMD_W-1:0] cmd, dsdff_pkg::frame_t data,
                           bit start);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tuser <= {start, cmd};
    do @(posedge clk); while (!s_tready);
    sb.note_word(cmd, data, start);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers back to back once the block has gone quiet.
  // Unused upper data bits carry junk, which the block must ignore.
  task automatic configure(logic [dsdff_pkg::CH_W-1:0] ch, logic [dsdff_pkg::CH_W-1:0] och,
                           logic [dsdff_pkg::READY_W-1:0] pbf,
                           logic [dsdff_pkg::TMO_W-1:0] tmo);
    logic [dsdff_pkg::CFG_A_W-1:0] idx [4];
    logic [dsdff_pkg::CFG_D_W-1:0] val [4];
    idx = '{dsdff_pkg::REG_CH_COUNT, dsdff_pkg::REG_OCH_COUNT, dsdff_pkg::REG_PB_FRAMES,
            dsdff_pkg::REG_PB_TMO};
    val[0] = {12'($urandom), ch};
    val[1] = {12'($urandom), och};
    val[2] = {4'($urandom), pbf};
    val[3] = tmo;
    wait_idle();
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_addr <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // One session: bursts of pushes, render calls, ticks, end of input and noise.
  task automatic random_session(int budget);
    int sent;
    int pick;
    int k;
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), rand_bit());
    sent = 1;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        k = $urandom_range(1, 12);
        repeat (k) send_word(dsdff_pkg::CMD_PUSH, rand_frame(), rand_bit());
      end else if (pick < 75) begin
        // Now and then a call starts without its start mark.
        k = $urandom_range(1, 10);
        for (int i = 0; i < k; i++)
          send_word(dsdff_pkg::CMD_PULL, rand_frame(), (i == 0) && (pick != 74));
      end else if (pick < 88) begin
        k = $urandom_range(1, 8);
        repeat (k) send_word(dsdff_pkg::CMD_TICK, rand_frame(), rand_bit());
      end else if (pick < 92) begin
        k = 1;
        send_word(dsdff_pkg::CMD_ENDED, rand_frame(), rand_bit());
      end else if (pick < 95) begin
        k = 1;
        send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), rand_bit());
      end else begin
        k = 1;
        send_word(dsdff_pkg::CMD_W'($urandom_range(0, 2**dsdff_pkg::CMD_W - 1)),
                  rand_frame(), rand_bit());
      end
      sent += k;
    end
  endtask

  initial begin
    logic [dsdff_pkg::CH_W-1:0]    ch;
    logic [dsdff_pkg::CH_W-1:0]    och;
    logic [dsdff_pkg::READY_W-1:0] pbf;
    logic [dsdff_pkg::TMO_W-1:0]   tmo;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: empty pull with no audio yet, data extremes, a call that
    // runs dry, unused commands, a pull after the end of input.
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_PUSH, '0, 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, '1, 1'b1);
    send_word(dsdff_pkg::CMD_PUSH, 64'h0123456789abcdef, 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    repeat (4) send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b0);
    for (int c = int'(dsdff_pkg::CMD_TICK) + 1; c < 2**dsdff_pkg::CMD_W; c++)
      send_word(dsdff_pkg::CMD_W'(c), rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_ENDED, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_TICK, rand_frame(), 1'b0);

    // Channel counts below and above range, then a zero output count.
    configure(4'd0, 4'd15, '0, '0);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    configure(4'd12, 4'd0, '0, '0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b0);

    // Prebuffer hold released by timeout, by a zero timeout, by the
    // threshold and by the end of input.
    configure(4'd3, 4'd5, 12'd3, 16'd2);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_TICK, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_TICK, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    configure(4'd2, 4'd2, 12'd2, 16'd0);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    configure(4'd8, 4'd3, 12'd2, 16'd100);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    configure(4'd4, 4'd8, 12'd5, 16'd100);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_ENDED, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);

    // Keep pushing while the result side holds off, so the input stalls,
    // then drain part of the store and refill it.
    configure(4'd8, 4'd8, '0, '0);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    long_hold = 1;
    repeat (60) send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    repeat (20) send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b0);
    repeat (10) send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);

    // A threshold out of reach, so only the timeout ends the hold.
    configure(4'd2, 4'd2, 12'd4095, 16'd30);
    send_word(dsdff_pkg::CMD_BEGIN, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PUSH, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    repeat (29) send_word(dsdff_pkg::CMD_TICK, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);
    send_word(dsdff_pkg::CMD_TICK, rand_frame(), 1'b0);
    send_word(dsdff_pkg::CMD_PULL, rand_frame(), 1'b1);

    // Random sessions under a range of settings, extremes first.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        configure(4'd8, 4'd8, 12'd4095, 16'hffff);
      end else if (ph == 1) begin
        configure(4'd1, 4'd1, '0, '0);
      end else begin
        ch = ($urandom_range(0, 5) == 0) ? dsdff_pkg::CH_W'($urandom) :
                                           dsdff_pkg::CH_W'($urandom_range(1, 8));
        och = ($urandom_range(0, 5) == 0) ? dsdff_pkg::CH_W'($urandom) :
                                            dsdff_pkg::CH_W'($urandom_range(1, 8));
        pbf = ($urandom_range(0, 3) == 0) ? '0 :
                                            dsdff_pkg::READY_W'($urandom_range(1, 20));
        tmo = ($urandom_range(0, 3) == 0) ? '0 : dsdff_pkg::TMO_W'($urandom_range(1, 40));
        configure(ch, och, pbf, tmo);
      end
      random_session(100);
    end

    // Closing stretch with no idling on either side.
    quiet = 1;
    configure(4'd6, 4'd7, 12'd8, 16'd12);
    random_session(150);

    s_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
